### sv/hslp_pkg.sv
// shared types and constants for the linear-probe hash set
`timescale 1ns / 1ps
`default_nettype none

package hslp_pkg;

  // default table geometry
  localparam int unsigned TABLE_DEPTH_DEF = 1024;
  localparam int unsigned KEY_LEN_DEF     = 8;

  // fixed field widths
  localparam int unsigned KEY_PORT_W = 64;
  localparam int unsigned HANDLE_W   = 16;
  localparam int unsigned HASH_W     = 64;

  // djb2 constants
  localparam logic [HASH_W-1:0] DJB_START = 64'd5381;
  localparam int unsigned       DJB_SHIFT = 5;

  // hash sequencer: one step per key byte, then one 16-bit digit per remainder step
  localparam int unsigned DIG_W      = 16;
  localparam int unsigned RED_DIGITS = HASH_W / DIG_W;
  localparam int unsigned CNT_W      = $clog2(HASH_W / 8);

  // command and status codes
  localparam logic CMD_LOOKUP  = 1'b0;
  localparam logic CMD_INSERT  = 1'b1;
  localparam logic STAT_DONE   = 1'b0;
  localparam logic STAT_FULL   = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_PROBE
  } state_e;

endpackage

`default_nettype wire

### sv/hslp_hash.sv
// djb2 hash over the key bytes, one byte per cycle, then reduction to a home slot
`timescale 1ns / 1ps
`default_nettype none

module hslp_hash import hslp_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int unsigned KEY_LEN     = KEY_LEN_DEF,
  localparam int unsigned IDX_W      = $clog2(TABLE_DEPTH),
  localparam int unsigned KEY_W      = 8 * KEY_LEN
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [KEY_W-1:0] key_i,
  output logic                  done_o,
  output logic [IDX_W-1:0]      home_o
);

  localparam bit          IS_POW2 = (TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0;
  localparam int unsigned MUL_W   = 2 * DIG_W;
  localparam int unsigned PROD_W  = 2 * MUL_W;
  localparam logic [CNT_W-1:0] LAST_BYTE = CNT_W'(KEY_LEN - 1);
  localparam logic [CNT_W-1:0] LAST_DIG  = CNT_W'(RED_DIGITS - 1);
  localparam logic [MUL_W-1:0] DEPTH_M   = MUL_W'(TABLE_DEPTH);
  // floor(2^32 / depth), the quotient estimate is then low by at most one
  localparam logic [MUL_W-1:0] RECIP     = MUL_W'((64'd1 << MUL_W) / TABLE_DEPTH);

  logic              run_q, run_d;
  logic              reduce_q, reduce_d;
  logic              phase_q, phase_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [HASH_W-1:0] h_q, h_d;
  logic [KEY_W-1:0]  key_q, key_d;
  logic [DIG_W-1:0]  rem_q, rem_d;
  logic [MUL_W-1:0]  quo_q, quo_d;
  logic [IDX_W-1:0]  home_q, home_d;

  logic [7:0]        byte_v;
  logic [HASH_W-1:0] byte_sx;
  logic [HASH_W-1:0] mix;
  logic [MUL_W-1:0]  digit_x;
  logic [MUL_W-1:0]  mul_a;
  logic [MUL_W-1:0]  mul_b;
  logic [PROD_W-1:0] prod;
  logic [MUL_W-1:0]  diff;
  logic [MUL_W-1:0]  rem_fix;

  // the shared datapath: h*33 + byte, and one multiplier for the digit remainder
  always_comb begin
    byte_v  = key_q[7:0];
    byte_sx = {{(HASH_W - 8){byte_v[7]}}, byte_v};
    mix     = (h_q << DJB_SHIFT) + h_q + byte_sx;
    // running remainder times 2^16 plus the next digit, msb digit first
    digit_x = {rem_q, h_q[HASH_W-1 -: DIG_W]};
    mul_a   = phase_q ? quo_q : digit_x;
    mul_b   = phase_q ? DEPTH_M : RECIP;
    prod    = PROD_W'(mul_a) * PROD_W'(mul_b);
    diff    = digit_x - prod[MUL_W-1:0];
    rem_fix = (diff >= DEPTH_M) ? diff - DEPTH_M : diff;
  end

  always_comb begin
    run_d    = run_q;
    reduce_d = reduce_q;
    phase_d  = phase_q;
    done_d   = 1'b0;
    cnt_d    = cnt_q;
    h_d      = h_q;
    key_d    = key_q;
    rem_d    = rem_q;
    quo_d    = quo_q;
    home_d   = home_q;
    if (start_i) begin
      run_d    = 1'b1;
      reduce_d = 1'b0;
      phase_d  = 1'b0;
      cnt_d    = '0;
      h_d      = DJB_START;
      key_d    = key_i;
    end else if (run_q && !reduce_q) begin
      h_d   = mix;
      key_d = key_q >> 8;
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == LAST_BYTE) begin
        cnt_d = '0;
        if (IS_POW2) begin
          run_d  = 1'b0;
          done_d = 1'b1;
          home_d = mix[IDX_W-1:0];
        end else begin
          reduce_d = 1'b1;
          phase_d  = 1'b0;
          rem_d    = '0;
        end
      end
    end else if (run_q) begin
      if (!phase_q) begin
        // quotient estimate from the reciprocal
        quo_d   = prod[PROD_W-1:MUL_W];
        phase_d = 1'b1;
      end else begin
        // back-multiply, subtract and one correction
        phase_d = 1'b0;
        rem_d   = rem_fix[DIG_W-1:0];
        h_d     = h_q << DIG_W;
        cnt_d   = cnt_q + CNT_W'(1);
        if (cnt_q == LAST_DIG) begin
          run_d    = 1'b0;
          reduce_d = 1'b0;
          done_d   = 1'b1;
          home_d   = rem_fix[IDX_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q    <= 1'b0;
      reduce_q <= 1'b0;
      phase_q  <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      run_q    <= run_d;
      reduce_q <= reduce_d;
      phase_q  <= phase_d;
      done_q   <= done_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    h_q    <= h_d;
    key_q  <= key_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    home_q <= home_d;
  end

  assign done_o = done_q;
  assign home_o = home_q;

endmodule

`default_nettype wire

### sv/hslp_mem.sv
// slot memory: valid mark, key and handle per slot, one write and one registered read port
`timescale 1ns / 1ps
`default_nettype none

module hslp_mem import hslp_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int unsigned KEY_W       = 8 * KEY_LEN_DEF,
  localparam int unsigned IDX_W      = $clog2(TABLE_DEPTH),
  localparam int unsigned SLOT_W     = 1 + KEY_W + HANDLE_W
) (
  input  wire logic                clk_i,
  input  wire logic                we_i,
  input  wire logic [IDX_W-1:0]    waddr_i,
  input  wire logic                wvalid_i,
  input  wire logic [KEY_W-1:0]    wkey_i,
  input  wire logic [HANDLE_W-1:0] whandle_i,
  input  wire logic                re_i,
  input  wire logic [IDX_W-1:0]    raddr_i,
  output logic                     rvalid_o,
  output logic [KEY_W-1:0]         rkey_o,
  output logic [HANDLE_W-1:0]      rhandle_o
);

  logic [SLOT_W-1:0] mem_q [TABLE_DEPTH];
  logic [SLOT_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= {wvalid_i, wkey_i, whandle_i};
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rvalid_o  = rdata_q[SLOT_W-1];
  assign rkey_o    = rdata_q[HANDLE_W +: KEY_W];
  assign rhandle_o = rdata_q[HANDLE_W-1:0];

endmodule

`default_nettype wire

### sv/hash_set_linear_probe.sv
// top level of the linear-probe hash set: command sequencer around hash unit and slot memory
//
// usage:
//   a command item (lookup or insert, key, handle) is taken on a rising edge with start_i
//   high and busy_o low. each item gives exactly one result, shown on found_o,
//   found_handle_o and status_o for the single cycle in which valid_o is high.
//   the receiver cannot hold a result off; the next item may be started in that cycle.
// operation:
//   the hash unit walks one key byte per cycle; for a table depth that is not a power
//   of two a remainder over four 16-bit digits follows, each digit a quotient estimate
//   from the reciprocal and then a back-multiply with one correction. the slot memory is
//   then probed at one read per cycle until the probe ends. the time a command takes is
//   set by the hash unit and by the number of slots probed through the single memory
//   read port. an insert into a full table (depth - 1 entries) is refused without
//   hashing; its full status is shown in the cycle after it is taken.
// reset:
//   after reset the block sweeps the memory clearing every valid mark, one slot per cycle,
//   with busy_o high. entry count is zero after reset.
`timescale 1ns / 1ps
`default_nettype none

module hash_set_linear_probe import hslp_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int unsigned KEY_LEN     = KEY_LEN_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  output logic                       busy_o,
  input  wire logic                  command_i,
  input  wire logic [KEY_PORT_W-1:0] key_i,
  input  wire logic [HANDLE_W-1:0]   handle_i,
  output logic                       valid_o,
  output logic                       found_o,
  output logic [HANDLE_W-1:0]        found_handle_o,
  output logic                       status_o
);

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
  localparam int unsigned KEY_W = 8 * KEY_LEN;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

  state_e state_q, state_d;

  logic [IDX_W-1:0]    clr_idx_q, clr_idx_d;
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic [IDX_W-1:0]    nprobe_q, nprobe_d;
  logic [IDX_W-1:0]    count_q, count_d;
  logic                cmd_q, cmd_d;
  logic [KEY_W-1:0]    key_q, key_d;
  logic [HANDLE_W-1:0] hnd_q, hnd_d;
  logic                res_valid_q, res_valid_d;
  logic                found_q, found_d;
  logic [HANDLE_W-1:0] fhnd_q, fhnd_d;
  logic                status_q, status_d;

  logic                accept;
  logic                table_full;
  logic                hash_done;
  logic [IDX_W-1:0]    hash_home;
  logic [IDX_W-1:0]    idx_nxt;
  logic                slot_hit;
  logic                slot_empty;
  logic                probe_end;

  logic                mem_we;
  logic [IDX_W-1:0]    mem_waddr;
  logic                mem_wvalid;
  logic                mem_re;
  logic [IDX_W-1:0]    mem_raddr;
  logic                mem_rvalid;
  logic [KEY_W-1:0]    mem_rkey;
  logic [HANDLE_W-1:0] mem_rhandle;

  hslp_hash #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_LEN     (KEY_LEN)
  ) u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept && !(command_i == CMD_INSERT && table_full)),
    .key_i   (key_i[KEY_W-1:0]),
    .done_o  (hash_done),
    .home_o  (hash_home)
  );

  hslp_mem #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_W       (KEY_W)
  ) u_mem (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wvalid_i  (mem_wvalid),
    .wkey_i    (key_q),
    .whandle_i (hnd_q),
    .re_i      (mem_re),
    .raddr_i   (mem_raddr),
    .rvalid_o  (mem_rvalid),
    .rkey_o    (mem_rkey),
    .rhandle_o (mem_rhandle)
  );

  always_comb begin
    accept     = start_i && (state_q == ST_IDLE);
    table_full = count_q >= LAST_IDX;
    idx_nxt    = (idx_q == LAST_IDX) ? '0 : idx_q + IDX_W'(1);
    slot_empty = !mem_rvalid;
    slot_hit   = mem_rvalid && (mem_rkey == key_q);
    // an insert always meets an empty slot since one is kept free
    if (cmd_q == CMD_INSERT) begin
      probe_end = slot_empty;
    end else begin
      probe_end = slot_empty || slot_hit || (nprobe_q == LAST_IDX);
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_idx_q == LAST_IDX) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept && !(command_i == CMD_INSERT && table_full)) state_d = ST_HASH;
      end
      ST_HASH: begin
        if (hash_done) state_d = ST_PROBE;
      end
      ST_PROBE: begin
        if (probe_end) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    clr_idx_d   = clr_idx_q;
    idx_d       = idx_q;
    nprobe_d    = nprobe_q;
    count_d     = count_q;
    cmd_d       = cmd_q;
    key_d       = key_q;
    hnd_d       = hnd_q;
    res_valid_d = 1'b0;
    found_d     = found_q;
    fhnd_d      = fhnd_q;
    status_d    = status_q;
    mem_we      = 1'b0;
    mem_waddr   = idx_q;
    mem_wvalid  = 1'b0;
    mem_re      = 1'b0;
    mem_raddr   = idx_nxt;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_idx_q;
        clr_idx_d = clr_idx_q + IDX_W'(1);
      end
      ST_IDLE: begin
        if (accept) begin
          cmd_d = command_i;
          key_d = key_i[KEY_W-1:0];
          hnd_d = handle_i;
          if (command_i == CMD_INSERT && table_full) begin
            res_valid_d = 1'b1;
            found_d     = 1'b0;
            fhnd_d      = '0;
            status_d    = STAT_FULL;
          end
        end
      end
      ST_HASH: begin
        mem_raddr = hash_home;
        if (hash_done) begin
          mem_re   = 1'b1;
          idx_d    = hash_home;
          nprobe_d = '0;
        end
      end
      ST_PROBE: begin
        if (probe_end) begin
          res_valid_d = 1'b1;
          status_d    = STAT_DONE;
          found_d     = (cmd_q == CMD_LOOKUP) && slot_hit;
          fhnd_d      = ((cmd_q == CMD_LOOKUP) && slot_hit) ? mem_rhandle : '0;
          if (cmd_q == CMD_INSERT) begin
            mem_we     = 1'b1;
            mem_wvalid = 1'b1;
            count_d    = count_q + IDX_W'(1);
          end
        end else begin
          // read the following slot while this one is checked
          mem_re   = 1'b1;
          idx_d    = idx_nxt;
          nprobe_d = nprobe_q + IDX_W'(1);
        end
      end
      default: begin
        mem_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_idx_q   <= '0;
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_idx_q   <= clr_idx_d;
      count_q     <= count_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    nprobe_q <= nprobe_d;
    cmd_q    <= cmd_d;
    key_q    <= key_d;
    hnd_q    <= hnd_d;
    found_q  <= found_d;
    fhnd_q   <= fhnd_d;
    status_q <= status_d;
  end

  assign busy_o         = state_q != ST_IDLE;
  assign valid_o        = res_valid_q;
  assign found_o        = found_q;
  assign found_handle_o = fhnd_q;
  assign status_o       = status_q;

endmodule

`default_nettype wire

### sv/hslp_checker.sv
// port-level checks for the hash set, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module hslp_checker import hslp_pkg::*; (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  start_i,
  input wire logic                  busy_o,
  input wire logic                  command_i,
  input wire logic                  valid_o,
  input wire logic                  found_o,
  input wire logic [HANDLE_W-1:0]   found_handle_o,
  input wire logic                  status_o
);

  // a refused insert never reports a hit
  a_full_not_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && status_o == STAT_FULL) |-> !found_o)
    else $error("full status together with found");

  // a miss carries a zero handle
  a_miss_zero_handle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !found_o) |-> (found_handle_o == '0))
    else $error("nonzero handle on a miss");

  // a lookup needs the hash first, so no result and the block busy right after
  a_lookup_takes_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && command_i == CMD_LOOKUP) |=> (busy_o && !valid_o))
    else $error("lookup finished in one cycle");

  // a lookup never answers with a full status
  a_lookup_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && command_i == CMD_LOOKUP) |=> (status_o == STAT_DONE || !valid_o))
    else $error("full status after a lookup");

endmodule

bind hash_set_linear_probe hslp_checker u_hslp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .command_i      (command_i),
  .valid_o        (valid_o),
  .found_o        (found_o),
  .found_handle_o (found_handle_o),
  .status_o       (status_o)
);

`default_nettype wire

### bench/tb.sv
// testbench for the linear-probe hash set, lookups and inserts checked against a shadow table
`timescale 1ns / 1ps

module tb;
  import hslp_pkg::*;

  localparam int unsigned DEPTH        = TABLE_DEPTH_DEF;
  localparam int unsigned KEY_LEN      = KEY_LEN_DEF;
  localparam logic [KEY_PORT_W-1:0] KEY_MASK =
    {KEY_PORT_W{1'b1}} >> (KEY_PORT_W - 8 * KEY_LEN);
  localparam int unsigned IDLE_LIMIT   = 8000;
  localparam int unsigned RANDOM_ITEMS = 634;

  typedef struct {
    logic                  cmd;
    logic [KEY_PORT_W-1:0] key;
    logic [HANDLE_W-1:0]   handle;
    int unsigned           gap;
    bit                    drain;
  } cmd_item_t;

  typedef struct {
    logic                found;
    logic [HANDLE_W-1:0] handle;
    logic                status;
  } answer_t;

  logic                  clk_i     = 1'b0;
  logic                  rst_ni    = 1'b0;
  logic                  start_i   = 1'b0;
  logic                  command_i = CMD_LOOKUP;
  logic [KEY_PORT_W-1:0] key_i     = '0;
  logic [HANDLE_W-1:0]   handle_i  = '0;
  logic                  busy_o;
  logic                  valid_o;
  logic                  found_o;
  logic [HANDLE_W-1:0]   found_handle_o;
  logic                  status_o;

  cmd_item_t             queued_cmds[$];
  answer_t               table_answers[$];
  logic [KEY_PORT_W-1:0] stored_keys[$];

  // shadow copy of the slot memory
  bit                    slot_used [DEPTH];
  logic [KEY_PORT_W-1:0] slot_key  [DEPTH];
  logic [HANDLE_W-1:0]   slot_hnd  [DEPTH];
  int unsigned           slot_count = 0;

  int unsigned mismatches  = 0;
  int unsigned idle_cycles = 0;
  int unsigned gap_cnt     = 0;
  int          in_flight   = 0;

  hash_set_linear_probe #(
    .TABLE_DEPTH(DEPTH),
    .KEY_LEN    (KEY_LEN)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .command_i     (command_i),
    .key_i         (key_i),
    .handle_i      (handle_i),
    .valid_o       (valid_o),
    .found_o       (found_o),
    .found_handle_o(found_handle_o),
    .status_o      (status_o)
  );

  always #6 clk_i = ~clk_i;

  // djb2 over sign-extended key bytes, reduced to a slot index
  function automatic int unsigned home_of(logic [KEY_PORT_W-1:0] key);
    logic [HASH_W-1:0] h;
    logic [7:0]        b;
    h = DJB_START;
    for (int i = 0; i < KEY_LEN; i++) begin
      b = key[8*i +: 8];
      h = (h << DJB_SHIFT) + h + {{(HASH_W-8){b[7]}}, b};
    end
    return 32'(h % DEPTH);
  endfunction

  function automatic answer_t probe_table(logic cmd, logic [KEY_PORT_W-1:0] key_raw,
                                          logic [HANDLE_W-1:0] hnd);
    answer_t               a;
    logic [KEY_PORT_W-1:0] key;
    int unsigned           slot;
    key  = key_raw & KEY_MASK;
    slot = home_of(key);
    a    = '{1'b0, '0, STAT_DONE};
    if (cmd == CMD_LOOKUP) begin
      for (int n = 0; n < DEPTH; n++) begin
        if (!slot_used[slot]) break;
        if (slot_key[slot] == key) begin
          a.found  = 1'b1;
          a.handle = slot_hnd[slot];
          break;
        end
        slot = (slot + 1) % DEPTH;
      end
    end else if (slot_count >= DEPTH - 1) begin
      a.status = STAT_FULL;
    end else begin
      while (slot_used[slot]) slot = (slot + 1) % DEPTH;
      slot_used[slot] = 1'b1;
      slot_key[slot]  = key;
      slot_hnd[slot]  = hnd;
      slot_count++;
    end
    return a;
  endfunction

  // random key with extra weight on the byte extremes
  function automatic logic [KEY_PORT_W-1:0] random_key();
    logic [KEY_PORT_W-1:0] k;
    k = {$urandom, $urandom};
    for (int i = 0; i < KEY_PORT_W / 8; i++) begin
      case ($urandom_range(0, 11))
        0: k[8*i +: 8] = 8'h00;
        1: k[8*i +: 8] = 8'h7f;
        2: k[8*i +: 8] = 8'h80;
        3: k[8*i +: 8] = 8'hff;
        default: ;
      endcase
    end
    return k;
  endfunction

  function automatic logic [KEY_PORT_W-1:0] key_with_home(int unsigned slot);
    logic [KEY_PORT_W-1:0] k;
    do k = random_key(); while (home_of(k) != slot);
    return k;
  endfunction

  function automatic logic [HANDLE_W-1:0] random_handle();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return HANDLE_W'($urandom);
    endcase
  endfunction

  task automatic queue_item(logic cmd, logic [KEY_PORT_W-1:0] key, logic [HANDLE_W-1:0] hnd,
                            int unsigned gap, bit drain);
    queued_cmds.push_back('{cmd, key, hnd, gap, drain});
    if (cmd == CMD_INSERT) begin
      stored_keys.push_back(key);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : driver
    bit took;
    int flight_now;
    if (!rst_ni) begin
      start_i   <= 1'b0;
      command_i <= CMD_LOOKUP;
      key_i     <= '0;
      handle_i  <= '0;
      gap_cnt   <= 0;
      in_flight <= 0;
    end else begin
      took       = start_i && !busy_o;
      flight_now = in_flight + (took ? 1 : 0) - (valid_o ? 1 : 0);
      in_flight <= flight_now;
      if (start_i && !took) begin
        // hold the item until the block takes it
      end else if (queued_cmds.size() == 0) begin
        start_i <= 1'b0;
      end else if (gap_cnt < queued_cmds[0].gap) begin
        start_i <= 1'b0;
        gap_cnt <= gap_cnt + 1;
      end else if (queued_cmds[0].drain && flight_now != 0) begin
        start_i <= 1'b0;
      end else begin
        start_i   <= 1'b1;
        command_i <= queued_cmds[0].cmd;
        key_i     <= queued_cmds[0].key;
        handle_i  <= queued_cmds[0].handle;
        gap_cnt   <= 0;
        void'(queued_cmds.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin : monitor
    answer_t want;
    if (rst_ni) begin
      if (valid_o) begin
        if (table_answers.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: found=%0b handle=%h status=%0b",
                     found_o, found_handle_o, status_o);
        end else begin
          want = table_answers.pop_front();
          if (found_o !== want.found || found_handle_o !== want.handle ||
              status_o !== want.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected found=%0b handle=%h status=%0b,",
                       want.found, want.handle, want.status,
                       " got found=%0b handle=%h status=%0b",
                       found_o, found_handle_o, status_o);
          end
        end
      end
      if (start_i && !busy_o)
        table_answers.push_back(probe_table(command_i, key_i, handle_i));
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (rst_ni) begin
      if ((start_i && !busy_o) || valid_o) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    logic [KEY_PORT_W-1:0] wrap_keys [3];
    logic [KEY_PORT_W-1:0] old_key;
    int unsigned           gap;
    int unsigned           gap_hi;
    int unsigned           pick;
    bit                    drain;

    // directed: empty table, extreme keys and handles, wrap at the table end, duplicates
    queue_item(CMD_LOOKUP, random_key(), random_handle(), 0, 1'b0);
    queue_item(CMD_INSERT, '0, '0, 0, 1'b0);
    queue_item(CMD_INSERT, '1, '1, 3, 1'b0);
    queue_item(CMD_INSERT, 64'h8080_8080_8080_8080, 16'h8000, 0, 1'b0);
    queue_item(CMD_INSERT, 64'h7f7f_7f7f_7f7f_7f7f, 16'h7fff, 14, 1'b0);
    queue_item(CMD_LOOKUP, '0, '1, 0, 1'b0);
    queue_item(CMD_LOOKUP, '1, '0, 0, 1'b0);
    queue_item(CMD_LOOKUP, 64'h8080_8080_8080_8080, random_handle(), 5, 1'b0);
    queue_item(CMD_LOOKUP, 64'h7f7f_7f7f_7f7f_7f7f, random_handle(), 0, 1'b0);
    for (int i = 0; i < 3; i++) begin
      wrap_keys[i] = key_with_home(DEPTH - 1);
      queue_item(CMD_INSERT, wrap_keys[i], random_handle(), $urandom_range(0, 14), 1'b0);
    end
    queue_item(CMD_LOOKUP, wrap_keys[2], random_handle(), 0, 1'b0);
    queue_item(CMD_LOOKUP, key_with_home(DEPTH - 1), random_handle(), 0, 1'b0);
    queue_item(CMD_INSERT, wrap_keys[0], random_handle(), 0, 1'b0);
    queue_item(CMD_LOOKUP, wrap_keys[0], random_handle(), 0, 1'b1);
    queue_item(CMD_LOOKUP, 64'h8000_0000_0000_0000, random_handle(), 0, 1'b0);
    queue_item(CMD_LOOKUP, 64'h0000_0000_0000_0001, random_handle(), 2, 1'b0);

    gap_hi = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 50 == 0) gap_hi = ($urandom_range(0, 2) == 0) ? 0 : 14;
      gap     = $urandom_range(0, gap_hi);
      drain   = (n % 100 == 0);
      pick    = $urandom_range(0, 99);
      old_key = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
      if (pick < 25)
        queue_item(CMD_INSERT, random_key(), random_handle(), gap, drain);
      else if (pick < 35)  // grow a cluster around a stored key
        queue_item(CMD_INSERT, key_with_home(home_of(old_key)), random_handle(), gap, drain);
      else if (pick < 42)
        queue_item(CMD_INSERT, old_key, random_handle(), gap, drain);
      else if (pick < 80)
        queue_item(CMD_LOOKUP, old_key, random_handle(), gap, drain);
      else if (pick < 90)  // miss that has to walk a cluster
        queue_item(CMD_LOOKUP, key_with_home(home_of(old_key)), random_handle(), gap, drain);
      else
        queue_item(CMD_LOOKUP, random_key(), random_handle(), gap, drain);
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(posedge clk_i); while (start_i || queued_cmds.size() != 0);
    while (table_answers.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (mismatches == 0 && table_answers.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
